@@ rtl/trbf_pkg.sv @@
// Shared types and constants for the two-reader broadcast FIFO.
package trbf_pkg;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned PAY_W = 64;
  localparam int unsigned REC_W = ID_W + PAY_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

@@ rtl/trbf_store.sv @@
// Record store: single-port RAM with registered read data.
module trbf_store import trbf_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [REC_W-1:0] wdata_i,
  output logic [REC_W-1:0] rdata_o
);

  logic [REC_W-1:0] mem_q [DEPTH];
  logic [REC_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/two_reader_broadcast_fifo.sv @@
// Two-reader broadcast FIFO of sensor records: top level.
//
// Input channel s_axis: tuser carries command (bit 0: 0 insert, 1 read) and
// reader (bit 1). tdata carries sensor_id [15:0] and sensor_payload [79:16].
// Output channel m_axis: one item per input item. tuser carries status
// (0 ok, 1 end marker read, 2 nothing unread, 3 full, insert rejected).
// tdata carries the record read, id [15:0] and payload [79:16], zero when
// the item is not a successful read.
// An insert appends a record; each reader reads records in order; a record
// is dropped once both readers have read it. Reads never wait.
// Output valid is registered and rises in the cycle after input accept; one
// item per cycle is sustained while m_axis does not stall, set by the single
// RAM port that serves either the insert write or the read of each item.
// Reset empties the FIFO (pointers and counters clear); RAM contents are not
// cleared. When m_axis stalls, the pending result is held and s_axis_tready
// drops until it is taken.
module two_reader_broadcast_fifo import trbf_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [REC_W-1:0] s_axis_tdata,  // sensor_id, sensor_payload
  input  logic [1:0]       s_axis_tuser,  // command, reader
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [REC_W-1:0] m_axis_tdata,  // read_sensor_id, read_payload
  output logic [1:0]       m_axis_tuser   // status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] taken0_q, taken0_d;
  logic [CW-1:0] taken1_q, taken1_d;
  logic          out_valid_q;
  status_e       status_q, status_d;
  logic          hit_q, hit_d;

  logic             accept;
  cmd_e             cmd;
  logic             reader;
  logic [CW-1:0]    taken_sel;
  logic [CW-1:0]    ofs;
  logic [SW-1:0]    slot_sum;
  logic [SW-1:0]    slot_wrap;
  logic [AW-1:0]    addr;
  logic             full;
  logic             empty;
  logic             mem_we;
  logic             mem_re;
  logic [CW-1:0]    t0n, t1n;
  logic [REC_W-1:0] rdata;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser[0]);
  assign reader        = s_axis_tuser[1];

  always_comb begin
    taken_sel = reader ? taken1_q : taken0_q;
    ofs       = (cmd == CMD_INSERT) ? count_q : taken_sel;
    slot_sum  = SW'(oldest_q) + SW'(ofs);
    slot_wrap = (slot_sum >= DepthS) ? slot_sum - DepthS : slot_sum;
    addr      = slot_wrap[AW-1:0];
    full      = (count_q == DepthC);
    empty     = (taken_sel >= count_q);

    oldest_d = oldest_q;
    count_d  = count_q;
    taken0_d = taken0_q;
    taken1_d = taken1_q;
    status_d = ST_OK;
    hit_d    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    t0n      = reader ? taken0_q : taken0_q + 1'b1;
    t1n      = reader ? taken1_q + 1'b1 : taken1_q;

    if (accept) begin
      case (cmd)
        CMD_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        CMD_READ: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            mem_re = 1'b1;
            hit_d  = 1'b1;
            if (t0n != '0 && t1n != '0) begin
              oldest_d = (oldest_q == LastSlot) ? '0 : oldest_q + 1'b1;
              count_d  = count_q - 1'b1;
              taken0_d = t0n - 1'b1;
              taken1_d = t1n - 1'b1;
            end else begin
              taken0_d = t0n;
              taken1_d = t1n;
            end
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      taken0_q    <= '0;
      taken1_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      taken0_q <= taken0_d;
      taken1_q <= taken1_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  trbf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (addr),
    .wdata_i (s_axis_tdata),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hit_q ? rdata : '0;

  always_comb begin
    if (hit_q && rdata[ID_W-1:0] == '0) begin
      m_axis_tuser = ST_END;
    end else begin
      m_axis_tuser = status_q;
    end
  end

endmodule

@@ rtl/trbf_checker.sv @@
// Port-level checks for the two-reader broadcast FIFO, bound to the top level.
module trbf_checker import trbf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [REC_W-1:0] m_axis_tdata,  // read_sensor_id, read_payload
  input logic [1:0]       m_axis_tuser   // status
);

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_no_data_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL)
      |-> m_axis_tdata == '0)
    else $error("failed item carries data");

  a_end_marker_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_END |-> m_axis_tdata[ID_W-1:0] == '0)
    else $error("end status with nonzero id");

endmodule

bind two_reader_broadcast_fifo trbf_checker u_trbf_checker (.*);
